[hdl/teb_pkg.sv]
package teb_pkg;

    localparam int unsigned COS_ENTRIES = 1024;
    localparam int unsigned COS_IDX_W   = $clog2(COS_ENTRIES);
    localparam int unsigned COS_ADDR_W  = COS_IDX_W + 1;
    localparam int unsigned COS_W       = 15;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    localparam logic [9:0]  RANGE_SCALE = 10'd1000;

    localparam logic [31:0] RST_ANGLE_STEP = 32'd2982616;
    localparam logic [15:0] RST_INV_DECEL  = 16'd7934;
    localparam logic [9:0]  RST_MARGIN_REV = 10'd120;
    localparam logic [9:0]  RST_MARGIN_FWD = 10'd20;

    typedef enum logic [1:0] {
        REG_ANGLE_STEP = 2'd0,
        REG_INV_DECEL  = 2'd1,
        REG_MARGIN_REV = 2'd2,
        REG_MARGIN_FWD = 2'd3
    } t_reg_idx;

    typedef logic [COS_W-1:0] t_cos_rom [COS_ENTRIES+1];

    // Q2.30 Taylor series, nine terms, rounded and saturated to unsigned Q0.15
    function automatic logic [COS_W-1:0] cos_q15_at(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x   = (64'(k) * HALF_PI_Q30) / COS_ENTRIES;
        x2  = (x * x) >> 30;
        mag = ONE_Q30;
        sum = $signed(ONE_Q30);
        mag = ((mag * x2) >> 30) / 64'd2;   sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd12;  sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd30;  sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd56;  sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd90;  sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd132; sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd182; sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd240; sum = sum + $signed(mag);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return r[COS_W-1:0];
    endfunction

    function automatic t_cos_rom cos_rom_init();
        t_cos_rom t;
        for (int unsigned k = 0; k <= COS_ENTRIES; k++) begin
            t[k] = cos_q15_at(k);
        end
        return t;
    endfunction

endpackage

[hdl/ttc_emergency_brake.sv]
// Time-to-collision emergency brake. Transfers with command 0 load the
// signed longitudinal speed; transfers with command 1 carry one lidar beam,
// whose angle (beam_index * angle_step minus a half turn) selects a cosine
// from a quarter-wave ROM. Brake is raised when range * 1000 is below
// threshold_ms * closing speed, the threshold being |speed| * inv_decel / 2^16
// plus the reverse or forward margin. One result is produced per input
// transfer, in order: odometry transfers return brake 0 and beam 0. The
// pipeline takes one transfer every clock while not stalled; its stages are
// the beam-angle multiply, the registered cosine ROM read, the speed by
// cosine multiply, the threshold by closing-speed multiply and the output
// register. Backpressure ripples back only as far as the first empty stage.
// Configuration writes are to be made only while the pipeline is empty.
module ttc_emergency_brake
    import teb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic signed [15:0] i_speed_mm_s,
    input  logic [15:0]        i_range_mm,
    input  logic               i_range_valid,
    input  logic [11:0]        i_beam_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_brake,
    output logic [11:0]        o_brake_beam,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam t_cos_rom COS_ROM = cos_rom_init();

    // configuration
    logic [31:0] r_angle_step;
    logic [15:0] r_inv_decel;
    logic [9:0]  r_margin_rev;
    logic [9:0]  r_margin_fwd;
    t_reg_idx    w_reg;

    logic signed [15:0] r_speed;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_acc;

    // stage 1
    logic               r_v1;
    logic               r_s1_ok;
    logic [11:0]        r_s1_beam;
    logic [15:0]        r_s1_range;
    logic signed [15:0] r_s1_speed;
    logic [31:0]        r_s1_angle;
    logic [31:0]        w_ang_prod;

    // stage 2
    logic               r_v2;
    logic               r_s2_ok;
    logic [11:0]        r_s2_beam;
    logic [25:0]        r_s2_rng;
    logic signed [15:0] r_s2_speed;
    logic               r_s2_neg;
    logic [COS_W-1:0]   r_s2_cos;
    logic [32:0]        r_s2_tprod;
    logic [1:0]         w_quad;
    logic [COS_IDX_W-1:0]  w_idx;
    logic [COS_ADDR_W-1:0] w_addr;
    logic [16:0]        w_mag;

    // stage 3
    logic               r_v3;
    logic               r_s3_ok;
    logic [11:0]        r_s3_beam;
    logic [25:0]        r_s3_rng;
    logic signed [31:0] r_s3_prod;
    logic [16:0]        r_s3_thr;
    logic signed [15:0] w_cos;

    // stage 4
    logic               r_v4;
    logic               r_s4_ok;
    logic [11:0]        r_s4_beam;
    logic [25:0]        r_s4_rng;
    logic [31:0]        r_s4_lim;
    logic [14:0]        w_closing;

    // output
    logic               r_o_valid;
    logic               r_o_brake;
    logic [11:0]        r_o_beam;

    assign w_rdy5  = !r_o_valid || !i_stall;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;
    assign w_acc   = i_valid && w_rdy1;

    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (w_reg)
            REG_ANGLE_STEP: prdata = r_angle_step;
            REG_INV_DECEL:  prdata = {16'd0, r_inv_decel};
            REG_MARGIN_REV: prdata = {22'd0, r_margin_rev};
            REG_MARGIN_FWD: prdata = {22'd0, r_margin_fwd};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_step <= RST_ANGLE_STEP;
            r_inv_decel  <= RST_INV_DECEL;
            r_margin_rev <= RST_MARGIN_REV;
            r_margin_fwd <= RST_MARGIN_FWD;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_ANGLE_STEP: r_angle_step <= pwdata;
                REG_INV_DECEL:  r_inv_decel  <= pwdata[15:0];
                REG_MARGIN_REV: r_margin_rev <= pwdata[9:0];
                REG_MARGIN_FWD: r_margin_fwd <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
        end else if (w_acc && !i_command) begin
            r_speed <= i_speed_mm_s;
        end
    end

    // stage 1: beam angle
    assign w_ang_prod = 32'({20'd0, i_beam_index} * r_angle_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_ok    <= i_command && i_range_valid;
            r_s1_beam  <= i_command ? i_beam_index : 12'd0;
            r_s1_range <= i_range_mm;
            r_s1_speed <= r_speed;
            r_s1_angle <= {~w_ang_prod[31], w_ang_prod[30:0]};
        end
    end

    // stage 2: cosine ROM, threshold product, scaled range
    assign w_quad = r_s1_angle[31:30];
    assign w_idx  = r_s1_angle[29 -: COS_IDX_W];
    assign w_addr = (w_quad[0]) ? COS_ADDR_W'(COS_ENTRIES) - {1'b0, w_idx} : {1'b0, w_idx};
    assign w_mag  = r_s1_speed[15] ? 17'(-{r_s1_speed[15], r_s1_speed})
                                   : {1'b0, r_s1_speed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_ok    <= r_s1_ok;
            r_s2_beam  <= r_s1_beam;
            r_s2_rng   <= 26'(r_s1_range * RANGE_SCALE);
            r_s2_speed <= r_s1_speed;
            r_s2_neg   <= w_quad[0] ^ w_quad[1];
            r_s2_cos   <= COS_ROM[w_addr];
            r_s2_tprod <= w_mag * {1'b0, r_inv_decel};
        end
    end

    // stage 3: speed times cosine, threshold
    assign w_cos = r_s2_neg ? -$signed({1'b0, r_s2_cos}) : $signed({1'b0, r_s2_cos});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_ok   <= r_s2_ok;
            r_s3_beam <= r_s2_beam;
            r_s3_rng  <= r_s2_rng;
            r_s3_prod <= r_s2_speed * w_cos;
            r_s3_thr  <= r_s2_tprod[32:16]
                         + {7'd0, (r_s2_speed[15] ? r_margin_rev : r_margin_fwd)};
        end
    end

    // stage 4: threshold times closing speed
    assign w_closing = r_s3_prod[29:15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_ok   <= r_s3_ok && (r_s3_prod > 32'sd0);
            r_s4_beam <= r_s3_beam;
            r_s4_rng  <= r_s3_rng;
            r_s4_lim  <= r_s3_thr * w_closing;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_rdy5) begin
            r_o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_o_brake <= r_s4_ok && ({6'd0, r_s4_rng} < r_s4_lim);
            r_o_beam  <= r_s4_beam;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_brake      = r_o_brake;
    assign o_brake_beam = r_o_beam;

    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_acc && !i_command) |=> $stable(r_speed))
        else $error("speed changed without an odometry transfer");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_o_valid && i_stall) |-> o_stall)
        else $error("input taken while pipeline full and stalled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && w_rdy5) |=> r_o_valid)
        else $error("result lost between last stage and output");

endmodule
